FILE: rtl/tbb_pkg.sv
// Shared types, constants and the term table of the tetrahedron Bernstein basis evaluator.
package tbb_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int IN_W          = 17;
    localparam int NEG_MAG_W     = IN_W + 2;
    localparam int IDX_W         = 6;
    localparam int VAL_W         = 23;
    localparam int ORD_W         = 3;
    localparam int COEF_W        = 5;
    localparam int S_TDATA_W     = 56;
    localparam int M_TDATA_W     = 32;
    localparam int TERM_COUNT    = 69;
    localparam int TERM_IDX_W    = 7;

    localparam logic [ORD_W-1:0] ORDER_RESET = 3'd1;
    localparam logic [ORD_W-1:0] ORDER_MAX   = 3'd4;

    localparam logic [VAL_W-1:0] VAL_MAXPOS = 23'h3FFFFF;
    localparam logic [VAL_W-1:0] VAL_MAXNEG = 23'h400000;

    // Indexed by order minus one
    localparam logic [IDX_W-1:0] ORDER_BASE [4] = '{6'd0, 6'd4, 6'd14, 6'd34};
    localparam logic [IDX_W-1:0] ORDER_LAST [4] = '{6'd3, 6'd9, 6'd19, 6'd34};

    typedef enum logic [2:0] {
        FAC_B1,
        FAC_B2,
        FAC_B3,
        FAC_B4,
        FAC_ONE
    } fac_t;

    typedef struct packed {
        logic [COEF_W-1:0] coef;
        logic              odd_b1;
        fac_t [3:0]        slot;
    } term_t;

    typedef struct packed {
        logic             vld;
        logic [IDX_W-1:0] idx;
        logic             last;
        logic [1:0]       ord;
        logic             sgn;
    } tag_t;

    function automatic int mag_width(int frac_bits);
        return (frac_bits + 1 > NEG_MAG_W) ? frac_bits + 1 : NEG_MAG_W;
    endfunction

    // Clamp the register to an order of 1..4, returned as order minus one
    function automatic logic [1:0] order_code(logic [ORD_W-1:0] k);
        logic [1:0] r;
        if (k == '0)
            r = 2'd0;
        else if (k >= ORDER_MAX)
            r = 2'd3;
        else
            r = 2'(k - 3'd1);
        return r;
    endfunction

    // Expand exponents into a list of factor slots, padded with unity
    function automatic term_t mk_term(int e0, int e1, int e2, int e3, int c);
        term_t r;
        int    ex [4];
        int    pos;
        ex[0] = e0;
        ex[1] = e1;
        ex[2] = e2;
        ex[3] = e3;
        pos = 0;
        r.coef   = COEF_W'(c);
        r.odd_b1 = 1'(e0 % 2);
        for (int i = 0; i < 4; i++)
            r.slot[i] = FAC_ONE;
        for (int f = 0; f < 4; f++)
            for (int rep = 0; rep < 4; rep++)
                if (rep < ex[f] && pos < 4)
                begin
                    r.slot[pos] = fac_t'(f);
                    pos++;
                end
        return r;
    endfunction

    localparam term_t TERMS [TERM_COUNT] = '{
        // order 1
        mk_term(1,0,0,0,1), mk_term(0,1,0,0,1), mk_term(0,0,1,0,1), mk_term(0,0,0,1,1),
        // order 2
        mk_term(2,0,0,0,1), mk_term(0,2,0,0,1), mk_term(0,0,2,0,1), mk_term(0,0,0,2,1),
        mk_term(0,0,1,1,2), mk_term(0,1,0,1,2), mk_term(0,1,1,0,2), mk_term(1,0,1,0,2),
        mk_term(1,0,0,1,2), mk_term(1,1,0,0,2),
        // order 3
        mk_term(3,0,0,0,1), mk_term(0,3,0,0,1), mk_term(0,0,3,0,1), mk_term(0,0,0,3,1),
        mk_term(0,0,2,1,3), mk_term(0,0,1,2,3), mk_term(0,1,0,2,3), mk_term(0,2,0,1,3),
        mk_term(0,2,1,0,3), mk_term(0,1,2,0,3), mk_term(1,0,2,0,3), mk_term(2,0,1,0,3),
        mk_term(2,0,0,1,3), mk_term(1,0,0,2,3), mk_term(2,1,0,0,3), mk_term(1,2,0,0,3),
        mk_term(0,1,1,1,6), mk_term(1,0,1,1,6), mk_term(1,1,0,1,6), mk_term(1,1,1,0,6),
        // order 4
        mk_term(4,0,0,0,1), mk_term(0,4,0,0,1), mk_term(0,0,4,0,1), mk_term(0,0,0,4,1),
        mk_term(3,1,0,0,4), mk_term(2,2,0,0,6), mk_term(1,3,0,0,4),
        mk_term(0,3,1,0,4), mk_term(0,2,2,0,6), mk_term(0,1,3,0,4),
        mk_term(1,0,3,0,4), mk_term(2,0,2,0,6), mk_term(3,0,1,0,4),
        mk_term(0,0,3,1,4), mk_term(0,0,2,2,6), mk_term(0,0,1,3,4),
        mk_term(3,0,0,1,4), mk_term(2,0,0,2,6), mk_term(1,0,0,3,4),
        mk_term(0,3,0,1,4), mk_term(0,2,0,2,6), mk_term(0,1,0,3,4),
        mk_term(2,1,1,0,12), mk_term(1,2,1,0,12), mk_term(1,1,2,0,12),
        mk_term(2,0,1,1,12), mk_term(1,0,1,2,12), mk_term(1,0,2,1,12),
        mk_term(2,1,0,1,12), mk_term(1,2,0,1,12), mk_term(1,1,0,2,12),
        mk_term(0,2,1,1,12), mk_term(0,1,2,1,12), mk_term(0,1,1,2,12),
        mk_term(1,1,1,1,24)
    };

endpackage

FILE: rtl/tbb_term_issue.sv
// Point register, term sequencer and factor selection stage.
module tbb_term_issue #(
    parameter int  FRAC_BITS = tbb_pkg::FRAC_BITS_DEF,
    localparam int MAG_W     = tbb_pkg::mag_width(FRAC_BITS)
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 load,
    input  logic [tbb_pkg::ORD_W-1:0]            poly_order,
    input  logic [tbb_pkg::IN_W-1:0]             coord_s,
    input  logic [tbb_pkg::IN_W-1:0]             coord_t,
    input  logic [tbb_pkg::IN_W-1:0]             coord_u,
    output logic                                 can_take,
    output tbb_pkg::tag_t                        tag_a,
    output logic [MAG_W-1:0]                     fac0,
    output logic [MAG_W-1:0]                     fac1,
    output logic [MAG_W-1:0]                     fac2,
    output logic [MAG_W+tbb_pkg::COEF_W-1:0]     fac3c
);
    import tbb_pkg::*;

    localparam int B_W = MAG_W + 2;
    localparam logic [B_W-1:0] ONE = B_W'(1) << FRAC_BITS;

    logic                  active_reg, active_next;
    logic [IDX_W-1:0]      j_reg, j_next;
    logic [1:0]            ord_reg;
    logic [MAG_W-1:0]      mag1_reg, mag2_reg, mag3_reg, mag4_reg;
    logic                  neg1_reg;
    logic [B_W-1:0]        b1;
    logic [B_W-1:0]        b1_abs;
    logic                  last_issue;
    logic [TERM_IDX_W-1:0] tidx;
    term_t                 tm;
    logic [MAG_W-1:0]      fac [4];
    tag_t                  tag_a_reg, tag_a_next;
    logic [MAG_W-1:0]      fac0_reg, fac1_reg, fac2_reg;
    logic [MAG_W+COEF_W-1:0] fac3c_reg, fac3c_next;

    // b1 = one - s - t - u, kept as sign and magnitude
    always_comb
    begin
        b1 = ONE - B_W'(coord_s) - B_W'(coord_t) - B_W'(coord_u);
        b1_abs = b1[B_W-1] ? B_W'(-b1) : b1;
    end

    assign last_issue = active_reg && (j_reg == ORDER_LAST[ord_reg]);
    assign can_take   = !active_reg || last_issue;

    always_comb
    begin
        active_next = active_reg;
        j_next      = j_reg;
        if (en && active_reg)
        begin
            j_next = j_reg + 1'b1;
            if (last_issue)
                active_next = 1'b0;
        end
        if (load)
        begin
            active_next = 1'b1;
            j_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            j_reg      <= '0;
        end
        else
        begin
            active_reg <= active_next;
            j_reg      <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ord_reg  <= order_code(poly_order);
            mag1_reg <= b1_abs[MAG_W-1:0];
            neg1_reg <= b1[B_W-1];
            mag2_reg <= MAG_W'(coord_s);
            mag3_reg <= MAG_W'(coord_t);
            mag4_reg <= MAG_W'(coord_u);
        end
    end

    // Look up the current term and pick its factors
    assign tidx = TERM_IDX_W'(ORDER_BASE[ord_reg]) + TERM_IDX_W'(j_reg);
    assign tm   = TERMS[tidx];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            case (tm.slot[i])
                FAC_B1:  fac[i] = mag1_reg;
                FAC_B2:  fac[i] = mag2_reg;
                FAC_B3:  fac[i] = mag3_reg;
                FAC_B4:  fac[i] = mag4_reg;
                default: fac[i] = MAG_W'(1);
            endcase
        end
        fac3c_next = (MAG_W+COEF_W)'(fac[3]) * (MAG_W+COEF_W)'(tm.coef);
        tag_a_next.vld  = active_reg;
        tag_a_next.idx  = j_reg;
        tag_a_next.last = last_issue;
        tag_a_next.ord  = ord_reg;
        tag_a_next.sgn  = neg1_reg & tm.odd_b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tag_a_reg <= '0;
        else if (en)
            tag_a_reg <= tag_a_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fac0_reg       <= fac[0];
            fac1_reg       <= fac[1];
            fac2_reg       <= fac[2];
            fac3c_reg      <= fac3c_next;
        end
    end

    assign tag_a = tag_a_reg;
    assign fac0  = fac0_reg;
    assign fac1  = fac1_reg;
    assign fac2  = fac2_reg;
    assign fac3c = fac3c_reg;

endmodule

FILE: rtl/tbb_product_pipe.sv
// Product, rounding and saturation pipeline; ends in the output register.
module tbb_product_pipe #(
    parameter int  FRAC_BITS = tbb_pkg::FRAC_BITS_DEF,
    localparam int MAG_W     = tbb_pkg::mag_width(FRAC_BITS)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  tbb_pkg::tag_t                     tag_a,
    input  logic [MAG_W-1:0]                  fac0,
    input  logic [MAG_W-1:0]                  fac1,
    input  logic [MAG_W-1:0]                  fac2,
    input  logic [MAG_W+tbb_pkg::COEF_W-1:0]  fac3c,
    output logic                              out_vld,
    output logic [tbb_pkg::IDX_W-1:0]         out_idx,
    output logic [tbb_pkg::VAL_W-1:0]         out_value,
    output logic                              out_last
);
    import tbb_pkg::*;

    localparam int P01_W = 2 * MAG_W;
    localparam int P23_W = 2 * MAG_W + COEF_W;
    localparam int L1    = MAG_W;
    localparam int H1    = P01_W - L1;
    localparam int L2    = MAG_W + 2;
    localparam int H2    = P23_W - L2;
    localparam int LL_W  = L1 + L2;
    localparam int LH_W  = L1 + H2;
    localparam int HL_W  = H1 + L2;
    localparam int HH_W  = H1 + H2;
    localparam int PW    = P01_W + P23_W;
    localparam int SUM_W = PW + 1;

    tag_t               tag_b_reg, tag_c_reg, tag_d_reg, tag_e_reg, tag_f_reg;
    logic [P01_W-1:0]   p01_reg, p01_next;
    logic [P23_W-1:0]   p23_reg, p23_next;
    logic [LL_W-1:0]    ll_reg, ll_next;
    logic [LH_W-1:0]    lh_reg, lh_next;
    logic [HL_W-1:0]    hl_reg, hl_next;
    logic [HH_W-1:0]    hh_reg, hh_next;
    logic [PW-1:0]      base_reg, base_next;
    logic [PW-1:0]      mid_reg, mid_next;
    logic [SUM_W-1:0]   rnd;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [SUM_W-1:0]   shifted;
    logic               big_reg, big_next;
    logic [VAL_W-1:0]   low_reg, low_next;
    logic               vld_g_reg;
    logic [IDX_W-1:0]   idx_g_reg;
    logic               last_g_reg;
    logic [VAL_W-1:0]   val_g_reg, val_g_next;

    // Stage B: two independent factor pairs
    assign p01_next = P01_W'(fac0) * P01_W'(fac1);
    assign p23_next = P23_W'(fac2) * P23_W'(fac3c);

    // Stage C: cross partial products of the two pair products
    assign ll_next = LL_W'(p01_reg[L1-1:0])     * LL_W'(p23_reg[L2-1:0]);
    assign lh_next = LH_W'(p01_reg[L1-1:0])     * LH_W'(p23_reg[P23_W-1:L2]);
    assign hl_next = HL_W'(p01_reg[P01_W-1:L1]) * HL_W'(p23_reg[L2-1:0]);
    assign hh_next = HH_W'(p01_reg[P01_W-1:L1]) * HH_W'(p23_reg[P23_W-1:L2]);

    // Stage D: outer products do not overlap, so concatenate them
    assign base_next = {hh_reg, ll_reg};
    assign mid_next  = (PW'(lh_reg) << L2) + (PW'(hl_reg) << L1);

    // Stage E: full product plus half an output lsb (no rounding term for order 1)
    always_comb
    begin
        case (tag_d_reg.ord)
            2'd0:    rnd = '0;
            2'd1:    rnd = SUM_W'(1) << (FRAC_BITS - 1);
            2'd2:    rnd = SUM_W'(1) << (2 * FRAC_BITS - 1);
            default: rnd = SUM_W'(1) << (3 * FRAC_BITS - 1);
        endcase
        sum_next = SUM_W'(base_reg) + SUM_W'(mid_reg) + rnd;
    end

    // Stage F: drop the surplus fraction bits, flag overrange
    always_comb
    begin
        case (tag_e_reg.ord)
            2'd0:    shifted = sum_reg;
            2'd1:    shifted = sum_reg >> FRAC_BITS;
            2'd2:    shifted = sum_reg >> (2 * FRAC_BITS);
            default: shifted = sum_reg >> (3 * FRAC_BITS);
        endcase
        big_next = |shifted[SUM_W-1:VAL_W];
        low_next = shifted[VAL_W-1:0];
    end

    // Stage G: saturate and apply sign
    always_comb
    begin
        if (tag_f_reg.sgn)
        begin
            if (big_reg || (low_reg[VAL_W-1] && |low_reg[VAL_W-2:0]))
                val_g_next = VAL_MAXNEG;
            else
                val_g_next = VAL_W'(-low_reg);
        end
        else
        begin
            if (big_reg || low_reg[VAL_W-1])
                val_g_next = VAL_MAXPOS;
            else
                val_g_next = low_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_b_reg <= '0;
            tag_c_reg <= '0;
            tag_d_reg <= '0;
            tag_e_reg <= '0;
            tag_f_reg <= '0;
            vld_g_reg <= 1'b0;
        end
        else if (en)
        begin
            tag_b_reg <= tag_a;
            tag_c_reg <= tag_b_reg;
            tag_d_reg <= tag_c_reg;
            tag_e_reg <= tag_d_reg;
            tag_f_reg <= tag_e_reg;
            vld_g_reg <= tag_f_reg.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p01_reg        <= p01_next;
            p23_reg        <= p23_next;
            ll_reg         <= ll_next;
            lh_reg         <= lh_next;
            hl_reg         <= hl_next;
            hh_reg         <= hh_next;
            base_reg       <= base_next;
            mid_reg        <= mid_next;
            sum_reg        <= sum_next;
            big_reg        <= big_next;
            low_reg        <= low_next;
            idx_g_reg      <= tag_f_reg.idx;
            last_g_reg     <= tag_f_reg.last;
            val_g_reg      <= val_g_next;
        end
    end

    assign out_vld   = vld_g_reg;
    assign out_idx   = idx_g_reg;
    assign out_value = val_g_reg;
    assign out_last  = last_g_reg;

endmodule

FILE: rtl/tet_bernstein_basis_eval.sv
// Top level of the tetrahedron Bernstein basis evaluator.
//
// Usage
//   Slave stream: one beat per point (s, t, u), unsigned with FRAC_BITS
//   fraction bits. Master stream: one beat per basis function, in the fixed
//   index order of the selected order, tlast on the final beat of a point.
//   cfg_we/cfg_wdata load the basis order (1..4; 0 acts as 1, 5..7 as 4);
//   write it only while no point is in flight.
// Throughput
//   One result beat per cycle while tready is high. A point issues 4, 10, 20
//   or 35 terms; the next point is taken in the cycle that issues the previous
//   point's last term, so points follow with no gap.
// Pipeline
//   After its beat is accepted, the first result of a point passes through
//   term issue, pair products, cross products, partial sum, full sum with
//   rounding, shift, then saturation into the output register.
// Reset and stall
//   Reset empties the pipeline and sets the order to 1. When the receiver
//   holds tready low with a beat waiting, the whole pipeline and the
//   sequencer hold, and no new point is taken until the beat moves.
module tet_bernstein_basis_eval #(
    parameter int FRAC_BITS = tbb_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [tbb_pkg::ORD_W-1:0]         cfg_wdata,      // poly_order
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [tbb_pkg::S_TDATA_W-1:0]     s_axis_tdata,   // coord_s, coord_t, coord_u
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [tbb_pkg::M_TDATA_W-1:0]     m_axis_tdata,   // basis_index, basis_value
    output logic                              m_axis_tlast    // last_of_point
);
    import tbb_pkg::*;

    localparam int MAG_W = mag_width(FRAC_BITS);
    localparam int PAD_W = M_TDATA_W - IDX_W - VAL_W;

    logic [ORD_W-1:0]        poly_order_reg;
    logic                    en;
    logic                    load;
    logic                    can_take;
    tag_t                    tag_a;
    logic [MAG_W-1:0]        fac0, fac1, fac2;
    logic [MAG_W+COEF_W-1:0] fac3c;
    logic                    out_vld;
    logic [IDX_W-1:0]        out_idx;
    logic [VAL_W-1:0]        out_value;
    logic                    out_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            poly_order_reg <= ORDER_RESET;
        else if (cfg_we)
            poly_order_reg <= cfg_wdata;
    end

    // Advance everything whenever the output register is free or draining
    assign en = !out_vld || m_axis_tready;

    // Take a point when the sequencer is idle or on its last term
    assign s_axis_tready = en && can_take;
    assign load          = s_axis_tvalid && s_axis_tready;

    tbb_term_issue #(
        .FRAC_BITS (FRAC_BITS)
    ) u_issue (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .load       (load),
        .poly_order (poly_order_reg),
        .coord_s    (s_axis_tdata[IN_W-1:0]),
        .coord_t    (s_axis_tdata[2*IN_W-1:IN_W]),
        .coord_u    (s_axis_tdata[3*IN_W-1:2*IN_W]),
        .can_take   (can_take),
        .tag_a      (tag_a),
        .fac0       (fac0),
        .fac1       (fac1),
        .fac2       (fac2),
        .fac3c      (fac3c)
    );

    tbb_product_pipe #(
        .FRAC_BITS (FRAC_BITS)
    ) u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .tag_a     (tag_a),
        .fac0      (fac0),
        .fac1      (fac1),
        .fac2      (fac2),
        .fac3c     (fac3c),
        .out_vld   (out_vld),
        .out_idx   (out_idx),
        .out_value (out_value),
        .out_last  (out_last)
    );

    assign m_axis_tvalid = out_vld;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_value, out_idx};
    assign m_axis_tlast  = out_last;

endmodule

FILE: rtl/tbb_checker.sv
// Port-level checks of the basis evaluator, bound to the top level.
module tbb_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [tbb_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic                          m_axis_tlast
);
    import tbb_pkg::*;

    logic [IDX_W-1:0] idx;
    assign idx = m_axis_tdata[IDX_W-1:0];

    // Hold a stalled beat
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output beat changed");

    // No point is taken while a result beat is stuck
    a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !(s_axis_tvalid && s_axis_tready))
        else $error("input taken during output stall");

    // A point ends only on the last index of some order
    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |->
            idx == ORDER_LAST[0] || idx == ORDER_LAST[1] ||
            idx == ORDER_LAST[2] || idx == ORDER_LAST[3])
        else $error("tlast on a non-final index");

    // A beat that is not the last stays below the largest index
    a_mid_idx: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> idx < ORDER_LAST[3])
        else $error("index out of range on a middle beat");

endmodule

bind tet_bernstein_basis_eval tbb_checker u_tbb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

FILE: test/tb_top.sv
// Self-checking testbench for the tetrahedron Bernstein basis evaluator.
`timescale 1ns / 1ps

module tb_top;

    import tbb_pkg::*;

    localparam int FB      = FRAC_BITS_DEF;
    localparam int UNIT    = 1 << FB;
    localparam int COORD_MAX = (1 << IN_W) - 1;

    // One input point and one basis beat, at the block's field widths
    typedef struct packed {
        logic [IN_W-1:0] s;
        logic [IN_W-1:0] t;
        logic [IN_W-1:0] u;
    } point_t;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic [VAL_W-1:0] value;
        logic             last;
    } basis_t;

    // Exponents of b1..b4 per basis function, one nibble each, b1 in the top nibble
    localparam logic [15:0] TERM_EXP [69] = '{
        16'h1000, 16'h0100, 16'h0010, 16'h0001,
        16'h2000, 16'h0200, 16'h0020, 16'h0002, 16'h0011, 16'h0101, 16'h0110,
        16'h1010, 16'h1001, 16'h1100,
        16'h3000, 16'h0300, 16'h0030, 16'h0003, 16'h0021, 16'h0012, 16'h0102,
        16'h0201, 16'h0210, 16'h0120, 16'h1020, 16'h2010, 16'h2001, 16'h1002,
        16'h2100, 16'h1200, 16'h0111, 16'h1011, 16'h1101, 16'h1110,
        16'h4000, 16'h0400, 16'h0040, 16'h0004, 16'h3100, 16'h2200, 16'h1300,
        16'h0310, 16'h0220, 16'h0130, 16'h1030, 16'h2020, 16'h3010, 16'h0031,
        16'h0022, 16'h0013, 16'h3001, 16'h2002, 16'h1003, 16'h0301, 16'h0202,
        16'h0103, 16'h2110, 16'h1210, 16'h1120, 16'h2011, 16'h1012, 16'h1021,
        16'h2101, 16'h1201, 16'h1102, 16'h0211, 16'h0121, 16'h0112, 16'h1111
    };
    localparam int TERM_BASE [5] = '{0, 0, 4, 14, 34};
    localparam int TERM_N    [5] = '{0, 4, 10, 20, 35};
    localparam int FACT      [5] = '{1, 1, 2, 6, 24};

    logic                 clk;
    logic                 rst_n         = 1'b0;
    logic                 cfg_we        = 1'b0;
    logic [ORD_W-1:0]     cfg_wdata     = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;   // coord_s, coord_t, coord_u
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;         // basis_index, basis_value
    logic                 m_axis_tlast;         // last_of_point

    tet_bernstein_basis_eval uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Points waiting to go out, and basis beats the block still owes us
    point_t           point_queue [$];
    basis_t           basis_due   [$];

    // Our copy of poly_order, updated on each register write
    logic [ORD_W-1:0] order_copy = ORDER_RESET;

    logic             in_fire = 1'b0;
    bit               sender_calm   = 1'b0;
    bit               receiver_calm = 1'b0;
    int unsigned      send_gap  = 0;
    int unsigned      stall_left = 0;
    int unsigned      fail_count = 0;
    int unsigned      points_sent = 0;
    int unsigned      beats_checked = 0;
    int unsigned      outside_count = 0;
    int unsigned      saturated_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Mostly no gap, some short ones, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Work out every basis beat that a point yields at the given order and queue them.
    // Full-precision product, one rounding to nearest with ties away from zero,
    // then saturation into the signed output range.
    function automatic void predict_basis(point_t p, logic [ORD_W-1:0] ord);
        int          k;
        int          base;
        int          n;
        int          sh;
        int          b1;
        int          e;
        int          divisor;
        logic [19:0] mag [4];
        logic        neg [4];
        logic [127:0] acc;
        logic        sgn;
        basis_t      r;

        // Out-of-range orders fold onto 1 and 4
        if (ord == '0)
            k = 1;
        else if (ord > ORDER_MAX)
            k = 4;
        else
            k = int'(ord);
        base = TERM_BASE[k];
        n    = TERM_N[k];
        sh   = (k - 1) * FB;

        b1 = UNIT - int'(p.s) - int'(p.t) - int'(p.u);
        neg[0] = (b1 < 0);
        mag[0] = 20'((b1 < 0) ? -b1 : b1);
        neg[1] = 1'b0;
        mag[1] = 20'(p.s);
        neg[2] = 1'b0;
        mag[2] = 20'(p.t);
        neg[3] = 1'b0;
        mag[3] = 20'(p.u);
        if (b1 < 0)
            outside_count++;

        for (int j = 0; j < n; j++)
        begin
            acc = 128'd1;
            sgn = 1'b0;
            divisor = 1;
            for (int f = 0; f < 4; f++)
            begin
                e = int'(TERM_EXP[base + j][15 - 4 * f -: 4]);
                divisor = divisor * FACT[e];
                for (int x = 0; x < e; x++)
                begin
                    acc = acc * mag[f];
                    sgn = sgn ^ neg[f];
                end
            end
            // Multinomial coefficient k! / (e1! e2! e3! e4!)
            acc = acc * (FACT[k] / divisor);
            if (sh > 0)
                acc = (acc + (128'd1 << (sh - 1))) >> sh;
            if (acc == '0)
                sgn = 1'b0;
            if (sgn && acc > 128'(VAL_MAXNEG))
            begin
                acc = 128'(VAL_MAXNEG);
                saturated_count++;
            end
            else if (!sgn && acc > 128'(VAL_MAXPOS))
            begin
                acc = 128'(VAL_MAXPOS);
                saturated_count++;
            end
            r.index = IDX_W'(j);
            r.value = acc[VAL_W-1:0];
            if (sgn)
                r.value = -r.value;
            r.last  = (j == n - 1);
            basis_due.push_back(r);
        end
    endfunction

    // Predict on every accepted input beat; flag it for the driver
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            predict_basis(point_t'({s_axis_tdata[IN_W-1:0],
                                    s_axis_tdata[2*IN_W-1:IN_W],
                                    s_axis_tdata[3*IN_W-1:2*IN_W]}), order_copy);
            points_sent++;
            in_fire <= 1'b1;
        end
        else
            in_fire <= 1'b0;
    end

    // Driver: hold a beat until taken, then idle for its gap and launch the next one
    always @(negedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (s_axis_tvalid && !in_fire)
            s_axis_tvalid <= 1'b1;
        else if (send_gap > 0)
        begin
            send_gap--;
            s_axis_tvalid <= 1'b0;
        end
        else if (point_queue.size() > 0)
        begin
            point_t p;
            p = point_queue.pop_front();
            s_axis_tdata  <= {{(S_TDATA_W - 3 * IN_W){1'b0}}, p.u, p.t, p.s};
            s_axis_tvalid <= 1'b1;
            send_gap = sender_calm ? 0 : pick_gap();
        end
        else
            s_axis_tvalid <= 1'b0;
    end

    // Receiver back-pressure: random stalls, none while calm
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (!receiver_calm && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
        end
    end

    // Monitor: compare each result beat with the oldest expectation, field by field
    always @(posedge clk)
    begin
        basis_t want;
        logic [IDX_W-1:0] got_index;
        logic [VAL_W-1:0] got_value;

        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_index = m_axis_tdata[IDX_W-1:0];
            got_value = m_axis_tdata[IDX_W+VAL_W-1:IDX_W];
            if (basis_due.size() == 0)
            begin
                $error("unexpected basis beat: index %0d value %0d",
                       got_index, $signed(got_value));
                fail_count++;
            end
            else
            begin
                want = basis_due.pop_front();
                beats_checked++;
                if (got_index !== want.index)
                begin
                    $error("basis_index mismatch: expected %0d, got %0d",
                           want.index, got_index);
                    fail_count++;
                end
                if (got_value !== want.value)
                begin
                    $error("basis_value mismatch: expected %0d, got %0d",
                           $signed(want.value), $signed(got_value));
                    fail_count++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $error("last_of_point mismatch: expected %0d, got %0d",
                           want.last, m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    task automatic queue_point(int unsigned s, int unsigned t, int unsigned u);
        point_t p;
        p.s = IN_W'(s);
        p.t = IN_W'(t);
        p.u = IN_W'(u);
        point_queue.push_back(p);
    endtask

    // Mostly points inside the simplex, some built from boundary coordinate values, some anywhere in 17 bits
    task automatic queue_random_point();
        int unsigned r;
        int unsigned s;
        int unsigned t;
        int unsigned u;
        int unsigned edges [5];

        edges = '{0, 1, UNIT - 1, UNIT, COORD_MAX};
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            s = $urandom_range(0, UNIT);
            t = $urandom_range(0, UNIT - s);
            u = $urandom_range(0, UNIT - s - t);
        end
        else if (r < 80)
        begin
            s = edges[$urandom_range(0, 4)];
            t = ($urandom_range(0, 1) == 0) ? edges[$urandom_range(0, 4)]
                                            : $urandom_range(0, COORD_MAX);
            u = edges[$urandom_range(0, 4)];
        end
        else
        begin
            s = $urandom_range(0, COORD_MAX);
            t = $urandom_range(0, COORD_MAX);
            u = $urandom_range(0, COORD_MAX);
        end
        queue_point(s, t, u);
    endtask

    // Wait until the sender is drained and every owed beat has arrived, then let the
    // pipeline settle
    task automatic wait_idle();
        while (point_queue.size() != 0 || s_axis_tvalid || basis_due.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic set_order(logic [ORD_W-1:0] ord);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = ord;
        @(negedge clk);
        cfg_we     = 1'b0;
        order_copy = ord;
    endtask

    initial
    begin
        logic [ORD_W-1:0] phase_order [8];

        phase_order = '{3'd2, 3'd3, 3'd1, 3'd4, 3'd5, 3'd0, 3'd7, 3'd6};

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset order: corners, origin, and a point far outside the simplex
        queue_point(0, 0, 0);
        queue_point(UNIT, 0, 0);
        queue_point(0, UNIT, 0);
        queue_point(0, 0, UNIT);
        queue_point(COORD_MAX, COORD_MAX, COORD_MAX);
        wait_idle();

        // Order 2: exact halves on both signs, ties round away from zero
        set_order(3'd2);
        queue_point(1, UNIT / 4, 0);
        queue_point(UNIT / 2 + UNIT / 4 + 1, UNIT / 4, 0);
        queue_point(UNIT / 3, UNIT / 3, UNIT / 3);
        wait_idle();

        // Highest order: corners, centroid, saturation in both directions, negative b1
        set_order(ORDER_MAX);
        queue_point(0, 0, 0);
        queue_point(UNIT, 0, 0);
        queue_point(0, UNIT, 0);
        queue_point(0, 0, UNIT);
        queue_point(UNIT / 4, UNIT / 4, UNIT / 4);
        queue_point(COORD_MAX, COORD_MAX, COORD_MAX);
        queue_point(UNIT, UNIT, 0);
        queue_point(1, 1, 1);
        wait_idle();

        // Orders outside 1..4 fold onto the nearest valid one
        set_order(3'd0);
        queue_point(UNIT / 2, 0, UNIT / 4);
        queue_point(COORD_MAX, 0, 0);
        wait_idle();
        set_order(3'd7);
        queue_point(UNIT / 8, UNIT / 2, UNIT / 8);
        queue_point(COORD_MAX, UNIT, 1);
        wait_idle();

        // Random phases, one per register value, with changing pressure on both sides
        for (int ph = 0; ph < 8; ph++)
        begin
            set_order(phase_order[ph]);
            sender_calm   = (ph == 2) || ($urandom_range(0, 3) == 0);
            receiver_calm = (ph == 2) || ($urandom_range(0, 3) == 0);
            for (int i = 0; i < 24; i++)
            begin
                // Hold the sender once mid-phase until the block has caught up
                if (ph == 3 && i == 12)
                    wait_idle();
                queue_random_point();
            end
            wait_idle();
        end

        sender_calm   = 1'b0;
        receiver_calm = 1'b0;
        wait_idle();
        repeat (20) @(posedge clk);

        $display("Checked %0d basis beats from %0d points over every poly_order setting",
                 beats_checked, points_sent);
        $display("Points with negative b1: %0d, saturated values: %0d",
                 outside_count, saturated_count);
        if (fail_count == 0 && basis_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: sim.f
rtl/tbb_pkg.sv
rtl/tbb_term_issue.sv
rtl/tbb_product_pipe.sv
rtl/tet_bernstein_basis_eval.sv
rtl/tbb_checker.sv
test/tb_top.sv
